// ===== src/ats_pkg.sv =====
// Package for the autoscaled traffic speed block.
// Holds register indexes, reset values and the configuration struct.
// Used by ats_lane, ats_merge and autoscaled_traffic_speed.
package ats_pkg;

  localparam int COUNTER_WIDTH_DEF = 64;
  localparam int RATE_WIDTH_DEF    = 8;

  localparam int MS_W   = 7;
  localparam int MSC_W  = 16;
  localparam int CNT4_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_POLLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_POLLS = 2'd3;

  localparam logic [CNT4_W-1:0] SKIP_POLLS_RST  = 4'd5;
  localparam logic [MS_W-1:0]   MAX_SPEED_RST   = 7'd8;
  localparam logic [MSC_W-1:0]  MIN_SCALE_RST   = 16'd10;
  localparam logic [CNT4_W-1:0] DECAY_POLLS_RST = 4'd5;
  localparam int                PEAK_RESET      = 10;

  typedef struct packed {
    logic [MS_W-1:0]   max_speed;
    logic [MSC_W-1:0]  min_scale;
    logic [CNT4_W-1:0] decay_polls;
  } lane_cfg_t;

endpackage

// ===== src/ats_lane.sv =====
// One direction of the speed calculation: delta, shift-add multiply,
// restoring divide by the peak, saturation and peak decay.
// Depends on ats_pkg.
module ats_lane #(
  parameter int COUNTER_WIDTH = ats_pkg::COUNTER_WIDTH_DEF,
  parameter int RATE_WIDTH    = ats_pkg::RATE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [COUNTER_WIDTH-1:0] total,
  input  ats_pkg::lane_cfg_t       cfg,
  output logic                     done,
  output logic [RATE_WIDTH-1:0]    rate
);
  import ats_pkg::*;

  localparam int CW    = COUNTER_WIDTH;
  localparam int RW    = RATE_WIDTH;
  localparam int NW    = CW + MS_W;
  localparam int STP_W = $clog2(NW);
  localparam logic [STP_W-1:0] MUL_LAST = STP_W'(MS_W - 1);
  localparam logic [STP_W-1:0] DIV_LAST = STP_W'(NW - 1);
  localparam logic [RW-1:0]    RATE_MAX = {RW{1'b1}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     prev_r, prev_nxt;
  logic [CW-1:0]     peak_r, peak_nxt;
  logic [CNT4_W-1:0] dcnt_r, dcnt_nxt;
  logic [RW-1:0]     rate_r, rate_nxt;
  logic [CW-1:0]     delta_r, delta_nxt;
  logic [CW-1:0]     div_r, div_nxt;
  logic [NW-1:0]     acc_r, acc_nxt;
  logic [NW-1:0]     mcand_r, mcand_nxt;
  logic [MS_W-1:0]   mplier_r, mplier_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     q_r, q_nxt;
  logic              over_r, over_nxt;
  logic [STP_W-1:0]  step_r, step_nxt;

  logic [CW-1:0] delta_in;
  logic [CW:0]   shifted;
  logic          ge;
  logic [RW-1:0] speed;
  logic [CW-1:0] floor_v;

  always_comb begin
    delta_in = (prev_r == '0) ? '0 : total - prev_r;
    shifted  = {rem_r, acc_r[NW-1]};
    ge       = shifted >= {1'b0, div_r};
    speed    = over_r ? RATE_MAX : q_r;
    if (speed == '0) begin
      speed = RW'(1);
    end
    floor_v  = CW'(cfg.min_scale);
  end

  always_comb begin
    state_nxt  = state_r;
    prev_nxt   = prev_r;
    peak_nxt   = peak_r;
    dcnt_nxt   = dcnt_r;
    rate_nxt   = rate_r;
    delta_nxt  = delta_r;
    div_nxt    = div_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    over_nxt   = over_r;
    step_nxt   = step_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (total == prev_r) begin
            rate_nxt  = '0;
            state_nxt = ST_DONE;
          end else begin
            prev_nxt   = total;
            delta_nxt  = delta_in;
            div_nxt    = (peak_r == '0) ? CW'(1) : peak_r;
            acc_nxt    = '0;
            mcand_nxt  = NW'(delta_in);
            mplier_nxt = cfg.max_speed;
            step_nxt   = '0;
            state_nxt  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[NW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MS_W-1:1]};
        step_nxt   = step_r + STP_W'(1);
        if (step_r == MUL_LAST) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          q_nxt     = '0;
          over_nxt  = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? CW'(shifted - {1'b0, div_r}) : shifted[CW-1:0];
        acc_nxt  = {acc_r[NW-2:0], 1'b0};
        over_nxt = over_r | q_r[RW-1];
        q_nxt    = {q_r[RW-2:0], ge};
        step_nxt = step_r + STP_W'(1);
        if (step_r == DIV_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        rate_nxt = speed;
        if (peak_r < delta_r) begin
          peak_nxt = delta_r;
        end else if (dcnt_r >= cfg.decay_polls) begin
          peak_nxt = (delta_r < floor_v) ? floor_v : delta_r;
          dcnt_nxt = '0;
        end else begin
          dcnt_nxt = dcnt_r + CNT4_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
      peak_r  <= CW'(PEAK_RESET);
      dcnt_r  <= '0;
      rate_r  <= '0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      peak_r  <= peak_nxt;
      dcnt_r  <= dcnt_nxt;
      rate_r  <= rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r  <= delta_nxt;
    div_r    <= div_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    over_r   <= over_nxt;
    step_r   <= step_nxt;
  end

  assign done = (state_r == ST_DONE);
  assign rate = rate_r;

endmodule

// ===== src/ats_merge.sv =====
// Merging stage: collects both lanes for an evaluated poll, or takes a skipped poll directly,
// then drives the output item register. Depends on ats_pkg.
module ats_merge #(
  parameter int RATE_WIDTH = ats_pkg::RATE_WIDTH_DEF,
  localparam int OUT_W = ((2 * RATE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  skip_go,
  input  logic                  eval_go,
  input  logic [1:0]            lane_done,
  input  logic [RATE_WIDTH-1:0] rx_rate,
  input  logic [RATE_WIDTH-1:0] tx_rate,
  output logic                  release_item,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tuser
);
  import ats_pkg::*;

  logic [1:0]            got_r, got_nxt;
  logic                  wait_r, wait_nxt;
  logic                  pend_r, pend_nxt;
  logic                  pend_ev_r, pend_ev_nxt;
  logic                  ovld_r, ovld_nxt;
  logic                  oev_r;
  logic [RATE_WIDTH-1:0] orx_r, otx_r;
  logic                  load;

  always_comb begin
    got_nxt     = got_r | lane_done;
    wait_nxt    = wait_r;
    pend_nxt    = pend_r;
    pend_ev_nxt = pend_ev_r;
    load        = pend_r && (!ovld_r || out_tready);
    ovld_nxt    = ovld_r && !out_tready;
    if (load) begin
      pend_nxt = 1'b0;
      ovld_nxt = 1'b1;
    end
    if (eval_go) begin
      wait_nxt = 1'b1;
      got_nxt  = '0;
    end
    if (skip_go) begin
      pend_nxt    = 1'b1;
      pend_ev_nxt = 1'b0;
    end
    if (wait_r && (&got_nxt)) begin
      wait_nxt    = 1'b0;
      pend_nxt    = 1'b1;
      pend_ev_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      got_r     <= '0;
      wait_r    <= 1'b0;
      pend_r    <= 1'b0;
      pend_ev_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      got_r     <= got_nxt;
      wait_r    <= wait_nxt;
      pend_r    <= pend_nxt;
      pend_ev_r <= pend_ev_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      orx_r <= rx_rate;
      otx_r <= tx_rate;
      oev_r <= pend_ev_r;
    end
  end

  assign release_item = load;
  assign out_tvalid   = ovld_r;
  assign out_tdata    = OUT_W'({otx_r, orx_r});
  assign out_tuser    = oev_r;

endmodule

// ===== src/autoscaled_traffic_speed.sv =====
// Top level of the autoscaled traffic speed block: poll skip counter,
// configuration registers, two direction lanes and the merging stage.
// Depends on ats_pkg, ats_lane and ats_merge.
// An evaluated poll with a changed counter passes through the 7-step multiply and the
// bit-serial divide in each lane before it reaches the output register; with both
// counters unchanged the lanes skip both, and a skipped poll bypasses the lanes.
// One item is in work at a time; the next can be accepted in the cycle after the result
// enters the output register.
// Reset is synchronous, active low, and restores the control and configuration registers
module autoscaled_traffic_speed #(
  parameter int COUNTER_WIDTH = ats_pkg::COUNTER_WIDTH_DEF,
  parameter int RATE_WIDTH    = ats_pkg::RATE_WIDTH_DEF,
  localparam int IN_W  = ((2 * COUNTER_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * RATE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_W-1:0]                  in_tdata,   // rx_total, tx_total
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_W-1:0]                 out_tdata,  // rx_rate, tx_rate
  output logic                             out_tuser,  // evaluated
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ats_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ats_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ats_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  logic [CNT4_W-1:0] skip_polls_r;
  logic [MS_W-1:0]   max_speed_r;
  logic [MSC_W-1:0]  min_scale_r;
  logic [CNT4_W-1:0] decay_polls_r;
  logic [CNT4_W-1:0] skip_cnt_r, skip_cnt_nxt;
  logic              busy_r, busy_nxt;

  logic            accept, skip_go, eval_go, release_item;
  lane_cfg_t       lane_cfg;
  logic [1:0]      lane_done;
  logic [RATE_WIDTH-1:0] rx_rate, tx_rate;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign skip_go   = accept && (skip_cnt_r < skip_polls_r);
  assign eval_go   = accept && !(skip_cnt_r < skip_polls_r);

  assign lane_cfg.max_speed   = max_speed_r;
  assign lane_cfg.min_scale   = min_scale_r;
  assign lane_cfg.decay_polls = decay_polls_r;

  always_comb begin
    skip_cnt_nxt = skip_cnt_r;
    busy_nxt     = busy_r;
    if (release_item) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt     = 1'b1;
      skip_cnt_nxt = skip_go ? skip_cnt_r + CNT4_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_polls_r  <= SKIP_POLLS_RST;
      max_speed_r   <= MAX_SPEED_RST;
      min_scale_r   <= MIN_SCALE_RST;
      decay_polls_r <= DECAY_POLLS_RST;
      skip_cnt_r    <= '0;
      busy_r        <= 1'b0;
    end else begin
      skip_cnt_r <= skip_cnt_nxt;
      busy_r     <= busy_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SKIP_POLLS:  skip_polls_r  <= cfg_data[CNT4_W-1:0];
          REG_MAX_SPEED:   max_speed_r   <= cfg_data[MS_W-1:0];
          REG_MIN_SCALE:   min_scale_r   <= cfg_data[MSC_W-1:0];
          REG_DECAY_POLLS: decay_polls_r <= cfg_data[CNT4_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  ats_lane #(
    .COUNTER_WIDTH(COUNTER_WIDTH),
    .RATE_WIDTH   (RATE_WIDTH)
  ) u_rx_lane (
    .clk  (clk),
    .rst_n(rst_n),
    .start(eval_go),
    .total(in_tdata[CW-1:0]),
    .cfg  (lane_cfg),
    .done (lane_done[0]),
    .rate (rx_rate)
  );

  ats_lane #(
    .COUNTER_WIDTH(COUNTER_WIDTH),
    .RATE_WIDTH   (RATE_WIDTH)
  ) u_tx_lane (
    .clk  (clk),
    .rst_n(rst_n),
    .start(eval_go),
    .total(in_tdata[2*CW-1:CW]),
    .cfg  (lane_cfg),
    .done (lane_done[1]),
    .rate (tx_rate)
  );

  ats_merge #(
    .RATE_WIDTH(RATE_WIDTH)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .skip_go     (skip_go),
    .eval_go     (eval_go),
    .lane_done   (lane_done),
    .rx_rate     (rx_rate),
    .tx_rate     (tx_rate),
    .release_item(release_item),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== tb/sv/autoscaled_traffic_speed_tb.sv =====
// Self-checking testbench for autoscaled_traffic_speed: directed polls, then
// random counter sequences under several register settings and flow-control mixes.
// Depends on ats_pkg and the autoscaled_traffic_speed RTL.
`timescale 1ns / 100ps

module autoscaled_traffic_speed_tb;
  import ats_pkg::*;

  localparam int CW = 64;
  localparam int RW = 8;
  localparam int IN_W = 2 * CW;
  localparam int OUT_W = 2 * RW;
  localparam int RATE_MAX = 2 ** RW - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int POLLS_PER_PHASE = 94;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic          evaluated;
    logic [RW-1:0] tx_rate;
    logic [RW-1:0] rx_rate;
  } speed_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  autoscaled_traffic_speed #(
    .COUNTER_WIDTH(CW),
    .RATE_WIDTH(RW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor copy of the registers and the per-direction state.
  logic [3:0]    cfg_skip;
  logic [6:0]    cfg_max;
  logic [15:0]   cfg_min;
  logic [3:0]    cfg_decay;
  logic [3:0]    skip_count;
  logic [CW-1:0] rx_prev, tx_prev, rx_peak, tx_peak;
  logic [3:0]    rx_decay, tx_decay;
  logic [RW-1:0] rx_held, tx_held;

  logic [IN_W-1:0] poll_pending[$];
  speed_t          speed_expect[$];
  speed_t          seen_speed, want_speed;
  idle_mode_e      idle_mode = IDLE_NONE;
  logic            in_fire = 1'b0;
  logic            hold_req = 1'b0;
  logic            hold_ack = 1'b0;
  int              hold_left = 0;
  int              quiet_cycles = 0;
  int              mismatch_count = 0;
  logic [CW-1:0]   rx_cur = '0;
  logic [CW-1:0]   tx_cur = '0;

  task automatic reset_model();
    cfg_skip = SKIP_POLLS_RST;
    cfg_max = MAX_SPEED_RST;
    cfg_min = MIN_SCALE_RST;
    cfg_decay = DECAY_POLLS_RST;
    skip_count = '0;
    rx_prev = '0;
    tx_prev = '0;
    rx_peak = CW'(PEAK_RESET);
    tx_peak = CW'(PEAK_RESET);
    rx_decay = '0;
    tx_decay = '0;
    rx_held = '0;
    tx_held = '0;
  endtask

  task automatic lane_update(input logic [CW-1:0] total, inout logic [CW-1:0] prev,
                             inout logic [CW-1:0] peak, inout logic [3:0] decay_cnt,
                             output logic [RW-1:0] speed);
    logic [CW-1:0] delta;
    logic [127:0]  num, den, quo;
    if (total == prev) begin
      speed = '0;
    end else begin
      delta = (prev == '0) ? '0 : total - prev;
      prev = total;
      num = 128'(delta);
      num = num * cfg_max;
      den = 128'(peak);
      if (den == '0) begin
        den = 128'd1;
      end
      quo = num / den;
      speed = (quo > RATE_MAX) ? RW'(RATE_MAX) : quo[RW-1:0];
      if (speed == '0) begin
        speed = RW'(1);
      end
      if (peak < delta) begin
        peak = delta;
      end else if (decay_cnt >= cfg_decay) begin
        peak = (delta < cfg_min) ? CW'(cfg_min) : delta;
        decay_cnt = '0;
      end else begin
        decay_cnt = decay_cnt + 4'd1;
      end
    end
  endtask

  task automatic predict_poll(input logic [IN_W-1:0] data);
    speed_t s;
    s.evaluated = 1'b0;
    if (skip_count < cfg_skip) begin
      skip_count = skip_count + 4'd1;
    end else begin
      skip_count = '0;
      s.evaluated = 1'b1;
      lane_update(data[CW-1:0], rx_prev, rx_peak, rx_decay, rx_held);
      lane_update(data[IN_W-1:CW], tx_prev, tx_peak, tx_decay, tx_held);
    end
    s.rx_rate = rx_held;
    s.tx_rate = tx_held;
    speed_expect.push_back(s);
  endtask

  task automatic note_mismatch(input string what, input speed_t want, input speed_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected rx=%0d tx=%0d ev=%0d, got rx=%0d tx=%0d ev=%0d", $realtime,
               what, want.rx_rate, want.tx_rate, want.evaluated, got.rx_rate, got.tx_rate,
               got.evaluated);
    end
  endtask

  // Input side: accept at the rising edge, drive at the falling edge.
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      predict_poll(in_tdata);
      void'(poll_pending.pop_front());
    end
  end

  always @(negedge clk) begin
    int send_pct;
    send_pct = (idle_mode == IDLE_SEND) ? 69 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    if (!in_tvalid || in_fire) begin
      if (poll_pending.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= poll_pending[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == IDLE_RECV) ? 69 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_speed.rx_rate = out_tdata[RW-1:0];
      seen_speed.tx_rate = out_tdata[2*RW-1:RW];
      seen_speed.evaluated = out_tuser;
      if (speed_expect.size() == 0) begin
        note_mismatch("unexpected item", '0, seen_speed);
      end else begin
        want_speed = speed_expect.pop_front();
        if (seen_speed.rx_rate !== want_speed.rx_rate ||
            seen_speed.tx_rate !== want_speed.tx_rate ||
            seen_speed.evaluated !== want_speed.evaluated) begin
          note_mismatch("speed mismatch", want_speed, seen_speed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("autoscaled_traffic_speed: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SKIP_POLLS:  cfg_skip = data[3:0];
      REG_MAX_SPEED:   cfg_max = data[6:0];
      REG_MIN_SCALE:   cfg_min = data[15:0];
      REG_DECAY_POLLS: cfg_decay = data[3:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int skip, input int maxs, input int mins, input int decay);
    write_reg(REG_SKIP_POLLS, CFG_DATA_W'(skip));
    write_reg(REG_MAX_SPEED, CFG_DATA_W'(maxs));
    write_reg(REG_MIN_SCALE, CFG_DATA_W'(mins));
    write_reg(REG_DECAY_POLLS, CFG_DATA_W'(decay));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (poll_pending.size() != 0 || speed_expect.size() != 0 || in_tvalid);
  endtask

  task automatic queue_poll(input logic [CW-1:0] rx, input logic [CW-1:0] tx);
    poll_pending.push_back({tx, rx});
  endtask

  function automatic logic [CW-1:0] next_total(input logic [CW-1:0] cur);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) begin
      return cur;
    end else if (pick < 8) begin
      return cur + $urandom_range(1, 60);
    end else if (pick < 11) begin
      return cur + $urandom_range(61, 4000);
    end else if (pick == 11) begin
      return cur + $urandom_range(0, 200000);
    end else if (pick == 12) begin
      return cur + {$urandom, $urandom};
    end else if (pick == 13) begin
      return {$urandom, $urandom};
    end else if (pick == 14) begin
      return CW'($urandom_range(0, 3));
    end
    return '1 - CW'($urandom_range(0, 5));
  endfunction

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset settings the sixth poll is the first one evaluated.
    for (int i = 1; i <= 6; i++) begin
      queue_poll(CW'(100 * i), '0);
    end
    wait_idle();

    program_regs(0, MAX_SPEED_RST, MIN_SCALE_RST, DECAY_POLLS_RST);
    queue_poll(64'd5, 64'd7);
    queue_poll(64'd5, 64'd7);
    queue_poll(64'd20, 64'd1007);
    queue_poll('1, '1);
    queue_poll(64'd3, 64'd0);
    queue_poll(64'd10, 64'd5);
    wait_idle();

    program_regs(0, 64, 1, 0);
    queue_poll(64'd30, 64'd20);
    queue_poll(64'd100000, 64'd1000000);
    queue_poll(64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF);
    wait_idle();

    // Zero max_speed gives speed 1 on any changed counter.
    program_regs(0, 0, MIN_SCALE_RST, DECAY_POLLS_RST);
    queue_poll(64'd40, 64'd50);
    queue_poll(64'd41, 64'd60);
    queue_poll(64'd41, 64'd70);
    wait_idle();

    // Zero min_scale lets the peak decay to zero, so the divisor becomes one.
    program_regs(0, MAX_SPEED_RST, 0, 0);
    queue_poll(64'd0, 64'd0);
    queue_poll(64'd5, 64'd5);
    queue_poll(64'd9, 64'd12);
    wait_idle();

    // Lowering skip_polls below the running count makes the next poll evaluated.
    program_regs(15, MAX_SPEED_RST, MIN_SCALE_RST, DECAY_POLLS_RST);
    for (int i = 0; i < 3; i++) begin
      queue_poll(CW'(200 + i), CW'(300 + i));
    end
    wait_idle();
    program_regs(2, MAX_SPEED_RST, MIN_SCALE_RST, DECAY_POLLS_RST);
    queue_poll(64'd250, 64'd330);
    queue_poll(64'd260, 64'd390);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        program_regs(0, 64, 1, 0);
      end else if (p == 1) begin
        program_regs(15, 1, 65535, 15);
      end else begin
        program_regs($urandom_range(0, 3), $urandom_range(1, 64),
                     $urandom_range(0, 1) ? $urandom_range(1, 200) : $urandom_range(1, 65535),
                     $urandom_range(0, 15));
      end
      idle_mode = idle_mode_e'(p % 4);
      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        rx_cur = next_total(rx_cur);
        tx_cur = next_total(tx_cur);
        queue_poll(rx_cur, tx_cur);
      end
      if (p == 4) begin
        hold_req = ~hold_req;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && speed_expect.size() == 0) begin
      $display("autoscaled_traffic_speed: match");
    end else begin
      $display("autoscaled_traffic_speed: mismatch");
    end
    $finish;
  end

endmodule
